[rtl/rdfc_pkg.sv]
// ----------------------------------------------------------------------------
// rdfc_pkg
// SP-box tables, key schedules and the block function of the chained
// four-round Feistel cipher.
// ----------------------------------------------------------------------------
`default_nettype none

package rdfc_pkg;

  typedef logic [31:0] box_t [64];
  typedef logic [31:0] sched_t [8];

  localparam logic [5:0] SIX_BITS = 6'h3F;

  localparam box_t BOX1 = '{
    32'h01010400, 32'h00000000, 32'h00010000, 32'h01010404, 32'h01010004, 32'h00010404,
    32'h00000004, 32'h00010000, 32'h00000400, 32'h01010400, 32'h01010404, 32'h00000400,
    32'h01000404, 32'h01010004, 32'h01000000, 32'h00000004, 32'h00000404, 32'h01000400,
    32'h01000400, 32'h00010400, 32'h00010400, 32'h01010000, 32'h01010000, 32'h01000404,
    32'h00010004, 32'h01000004, 32'h01000004, 32'h00010004, 32'h00000000, 32'h00000404,
    32'h00010404, 32'h10000000, 32'h00010000, 32'h01010404, 32'h00000004, 32'h01010000,
    32'h01010400, 32'h01000000, 32'h01000000, 32'h00000400, 32'h01010004, 32'h00010000,
    32'h00010400, 32'h01000004, 32'h00000400, 32'h00000004, 32'h01000404, 32'h00010404,
    32'h01010404, 32'h00010004, 32'h01010000, 32'h01000404, 32'h01000004, 32'h00000404,
    32'h00010404, 32'h01010400, 32'h00000404, 32'h01000400, 32'h01000400, 32'h00000000,
    32'h00010004, 32'h00010400, 32'h00000000, 32'h01010004};

  localparam box_t BOX2 = '{
    32'h80108020, 32'h80008000, 32'h00008000, 32'h00108020, 32'h00100000, 32'h00000020,
    32'h80100020, 32'h80008020, 32'h80000020, 32'h80108020, 32'h80108000, 32'h80000000,
    32'h80008000, 32'h00100000, 32'h00000020, 32'h80100020, 32'h00108000, 32'h00100020,
    32'h80008020, 32'h00000001, 32'h80000000, 32'h00080000, 32'h00108020, 32'h80100000,
    32'h00100020, 32'h80000020, 32'h00000000, 32'h00108000, 32'h00008020, 32'h80108000,
    32'h80100000, 32'h00008020, 32'h00000000, 32'h00108020, 32'h80100020, 32'h00100000,
    32'h80008020, 32'h80100000, 32'h80108000, 32'h00008000, 32'h80100000, 32'h80008000,
    32'h00000020, 32'h80108020, 32'h00108020, 32'h00000020, 32'h00008000, 32'h80000000,
    32'h00008020, 32'h80108000, 32'h00100000, 32'h80000020, 32'h00100020, 32'h80008020,
    32'h80000020, 32'h00100020, 32'h00108000, 32'h00000000, 32'h80008000, 32'h00008020,
    32'h80000000, 32'h80100020, 32'h80108020, 32'h00108000};

  localparam box_t BOX3 = '{
    32'h00000208, 32'h08020200, 32'h00000000, 32'h08020008, 32'h08000200, 32'h00000000,
    32'h00020208, 32'h08000200, 32'h00020008, 32'h08000008, 32'h08000008, 32'h00020000,
    32'h08020208, 32'h00020008, 32'h08020000, 32'h00000208, 32'h08000000, 32'h00000008,
    32'h08022000, 32'h00000200, 32'h00020200, 32'h08020000, 32'h08020008, 32'h00020208,
    32'h08000208, 32'h00020200, 32'h00020000, 32'h08000208, 32'h00000008, 32'h80020208,
    32'h00000200, 32'h08000000, 32'h08020200, 32'h08000000, 32'h00020008, 32'h00000208,
    32'h00020000, 32'h08020200, 32'h08000200, 32'h00000000, 32'h00000200, 32'h00020008,
    32'h08020208, 32'h08000200, 32'h08000008, 32'h00000200, 32'h00000000, 32'h08020008,
    32'h08000208, 32'h00020000, 32'h08000000, 32'h08020208, 32'h00000008, 32'h00020208,
    32'h00020200, 32'h08000008, 32'h08020000, 32'h08000208, 32'h00000208, 32'h08020000,
    32'h00020208, 32'h00000008, 32'h08020008, 32'h00020200};

  localparam box_t BOX4 = '{
    32'h00802001, 32'h00002081, 32'h00002081, 32'h00000080, 32'h00802080, 32'h00800081,
    32'h00800001, 32'h00002001, 32'h00000000, 32'h00802000, 32'h00802000, 32'h00802081,
    32'h00000081, 32'h00000000, 32'h00800080, 32'h00800001, 32'h00000001, 32'h00002000,
    32'h00800000, 32'h00802001, 32'h00000080, 32'h00800000, 32'h00002001, 32'h00002080,
    32'h00800081, 32'h00000001, 32'h00002080, 32'h00800080, 32'h00002000, 32'h00802080,
    32'h00802081, 32'h00000081, 32'h00800080, 32'h00800001, 32'h00802000, 32'h00802081,
    32'h00000081, 32'h00000000, 32'h00000000, 32'h00802000, 32'h00002080, 32'h00800080,
    32'h00800081, 32'h00000001, 32'h00802001, 32'h00002081, 32'h00002081, 32'h00000080,
    32'h00802081, 32'h00000081, 32'h00000001, 32'h00002001, 32'h00800001, 32'h00002001,
    32'h00802080, 32'h00800081, 32'h00002001, 32'h00002080, 32'h00800000, 32'h00802001,
    32'h00000080, 32'h00800000, 32'h00002000, 32'h00802080};

  localparam box_t BOX5 = '{
    32'h00000100, 32'h02080100, 32'h02080000, 32'h42000100, 32'h00080000, 32'h00000100,
    32'h40000000, 32'h02080000, 32'h40080100, 32'h00080000, 32'h02000100, 32'h40080100,
    32'h42000100, 32'h42080000, 32'h00080100, 32'h40000000, 32'h02000000, 32'h40080000,
    32'h40080000, 32'h00000000, 32'h40000100, 32'h42080100, 32'h42080100, 32'h02000100,
    32'h42080000, 32'h40000100, 32'h00000000, 32'h42000000, 32'h02080100, 32'h02000000,
    32'h42000000, 32'h00080100, 32'h00080000, 32'h42000100, 32'h00001000, 32'h02000000,
    32'h40000000, 32'h02080000, 32'h42000100, 32'h40080100, 32'h02000100, 32'h40000000,
    32'h42080000, 32'h02080100, 32'h40080100, 32'h00000100, 32'h02000000, 32'h42080000,
    32'h42080100, 32'h00080100, 32'h42000000, 32'h42080100, 32'h02080000, 32'h00000000,
    32'h40080000, 32'h42000000, 32'h00080100, 32'h02000100, 32'h40000100, 32'h00080000,
    32'h00000000, 32'h40080000, 32'h02080100, 32'h40000100};

  localparam box_t BOX6 = '{
    32'h20000010, 32'h20400000, 32'h00004000, 32'h20404010, 32'h20400000, 32'h00000010,
    32'h20404010, 32'h00400000, 32'h20004000, 32'h00404010, 32'h00400000, 32'h20000010,
    32'h00400010, 32'h20004000, 32'h20000000, 32'h00004010, 32'h00000000, 32'h00400010,
    32'h20004010, 32'h00004000, 32'h00404000, 32'h20004010, 32'h00000010, 32'h20400010,
    32'h20400010, 32'h00000000, 32'h00404010, 32'h20404000, 32'h00004010, 32'h00404000,
    32'h20404000, 32'h20000000, 32'h20004000, 32'h00000010, 32'h20400010, 32'h00404000,
    32'h20404010, 32'h00400000, 32'h00004010, 32'h20000010, 32'h00400000, 32'h20004000,
    32'h20000000, 32'h00004010, 32'h20000010, 32'h20404010, 32'h00404000, 32'h20400000,
    32'h00404010, 32'h20404000, 32'h00000000, 32'h20400010, 32'h00000010, 32'h00004000,
    32'h20400000, 32'h00404010, 32'h00004000, 32'h00400010, 32'h20004010, 32'h00000000,
    32'h20404000, 32'h20000000, 32'h00400010, 32'h20004010};

  localparam box_t BOX7 = '{
    32'h00200000, 32'h04200002, 32'h04000802, 32'h00000000, 32'h00000800, 32'h04000802,
    32'h00200802, 32'h04200800, 32'h40200802, 32'h00200000, 32'h00000000, 32'h04000002,
    32'h00000002, 32'h04000000, 32'h04200002, 32'h00000802, 32'h04000800, 32'h00200802,
    32'h00200002, 32'h04000800, 32'h04000002, 32'h04200000, 32'h04200800, 32'h00200002,
    32'h04200000, 32'h00000800, 32'h00000802, 32'h04200802, 32'h00200800, 32'h00000002,
    32'h04000000, 32'h00200800, 32'h04000000, 32'h00200800, 32'h00200000, 32'h04000802,
    32'h04000802, 32'h04200002, 32'h04200002, 32'h00000002, 32'h00200002, 32'h04000000,
    32'h04000800, 32'h00200000, 32'h04200800, 32'h00000802, 32'h00200802, 32'h04200800,
    32'h00000802, 32'h04000002, 32'h04200802, 32'h04200000, 32'h00200800, 32'h00000000,
    32'h00000002, 32'h04200802, 32'h00000000, 32'h00200802, 32'h04200000, 32'h00000800,
    32'h04000002, 32'h04000800, 32'h00000800, 32'h00200002};

  localparam box_t BOX8 = '{
    32'h10001040, 32'h00001000, 32'h00040000, 32'h10041040, 32'h10000000, 32'h10001040,
    32'h00000040, 32'h10000000, 32'h00040040, 32'h10040000, 32'h10041040, 32'h00041000,
    32'h10041000, 32'h00041040, 32'h00001000, 32'h00000040, 32'h10040000, 32'h10000040,
    32'h10001000, 32'h00001040, 32'h00041000, 32'h00040040, 32'h10040040, 32'h10041000,
    32'h00001040, 32'h00000000, 32'h00000000, 32'h10040040, 32'h10000040, 32'h10001000,
    32'h00041040, 32'h00040000, 32'h00041040, 32'h00040000, 32'h10041000, 32'h00001000,
    32'h00000040, 32'h10040040, 32'h00001000, 32'h00041040, 32'h10001000, 32'h00000040,
    32'h10000040, 32'h10040000, 32'h10040040, 32'h10000000, 32'h00040000, 32'h10001040,
    32'h00000000, 32'h10041040, 32'h00040040, 32'h10000040, 32'h10040000, 32'h10001000,
    32'h10001040, 32'h00000000, 32'h10041040, 32'h00041000, 32'h00041000, 32'h00001040,
    32'h00001040, 32'h00040040, 32'h10000000, 32'h10041000};

  localparam sched_t SCHED_ENC = '{
    32'h64616420, 32'h003F7964, 32'h276F6877, 32'h6F792073,
    32'h64616420, 32'h003F7964, 32'h276F6877, 32'h6F792073};

  localparam sched_t SCHED_DEC = '{
    32'h276F6877, 32'h6F792073, 32'h64616420, 32'h003F7964,
    32'h276F6877, 32'h6F792073, 32'h64616420, 32'h003F7964};

  function automatic logic [31:0] half_round(logic [31:0] r, logic [31:0] k0,
                                             logic [31:0] k1);
    logic [31:0] a;
    logic [31:0] b;
    a = {r[3:0], r[31:4]} ^ k0;
    b = r ^ k1;
    return BOX7[a[5:0] & SIX_BITS] | BOX5[a[13:8] & SIX_BITS] |
           BOX3[a[21:16] & SIX_BITS] | BOX1[a[29:24] & SIX_BITS] |
           BOX8[b[5:0] & SIX_BITS] | BOX6[b[13:8] & SIX_BITS] |
           BOX4[b[21:16] & SIX_BITS] | BOX2[b[29:24] & SIX_BITS];
  endfunction

  function automatic logic [63:0] crypt_block(logic [63:0] x, logic dec);
    logic [31:0] lo;
    logic [31:0] hi;
    sched_t ks;
    lo = x[31:0];
    hi = x[63:32];
    ks = dec ? SCHED_DEC : SCHED_ENC;
    for (int i = 0; i < 2; i++) begin
      lo = lo ^ half_round(hi, ks[4*i], ks[4*i+1]);
      hi = hi ^ half_round(lo, ks[4*i+2], ks[4*i+3]);
    end
    return {lo, hi};
  endfunction

endpackage

`default_nettype wire

[rtl/reduced_des_feistel_chained_cipher.sv]
// ----------------------------------------------------------------------------
// reduced_des_feistel_chained_cipher
// Chained four-round Feistel block cipher with fixed keys and a four-entry
// result queue.
// ----------------------------------------------------------------------------
// Channel  Direction  tdata         tuser                      tlast
// s_*      in         block_data    first_item, direction      final_item
// m_*      out        result_block  -                          result_last
//
// Each item is ciphered in the cycle it is accepted and its zero to two
// results are written to a four-entry queue; the queue read side drives m_*.
// One item per cycle is taken while the queue holds at most two entries.
// A result is written to the queue at the edge that accepts its item and reaches m_* once earlier entries are taken.
// Reset clears the chain and the pending flag and empties the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module reduced_des_feistel_chained_cipher (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // block_data
  input  wire logic [1:0]  s_tuser,   // first_item, direction
  input  wire logic        s_tlast,   // final_item
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata,   // result_block
  output logic             m_tlast    // result_last
);

  logic [63:0] chain_block;
  logic [63:0] chain_block_next;
  logic        pending;
  logic        pending_next;
  logic [64:0] queue [4];
  logic [1:0]  wr_ptr;
  logic [1:0]  rd_ptr;
  logic [2:0]  count;
  logic [2:0]  count_next;

  logic        accept;
  logic        pop;
  logic [63:0] chain_eff;
  logic        pend_eff;
  logic [63:0] crypt_in;
  logic [63:0] crypt_out;
  logic [1:0]  num;
  logic [64:0] res0;
  logic [64:0] res1;

  assign s_tready = (count <= 3'd2);
  assign accept   = s_tvalid && s_tready;
  assign m_tvalid = (count != 3'd0);
  assign pop      = m_tvalid && m_tready;
  assign m_tdata  = queue[rd_ptr][63:0];
  assign m_tlast  = queue[rd_ptr][64];

  assign chain_eff = s_tuser[1] ? 64'd0 : chain_block;
  assign pend_eff  = s_tuser[1] ? 1'b0 : pending;
  assign crypt_in  = s_tuser[0] ? s_tdata : (s_tdata ^ chain_eff);
  assign crypt_out = rdfc_pkg::crypt_block(crypt_in, s_tuser[0]);

  always_comb begin
    res0 = {1'b1, crypt_out};
    res1 = {1'b1, crypt_out};
    num  = 2'd1;
    chain_block_next = crypt_out;
    pending_next = 1'b0;
    if (s_tuser[0]) begin
      pending_next = !s_tlast;
      if (pend_eff) begin
        res0 = {!s_tlast, chain_eff ^ s_tdata};
        num  = s_tlast ? 2'd2 : 2'd1;
      end else begin
        num = s_tlast ? 2'd1 : 2'd0;
      end
    end
    count_next = count - {2'd0, pop};
    if (accept) begin
      count_next = count_next + {1'b0, num};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain_block <= '0;
      pending     <= 1'b0;
      wr_ptr      <= '0;
      rd_ptr      <= '0;
      count       <= '0;
    end else begin
      count <= count_next;
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      if (accept) begin
        chain_block <= chain_block_next;
        pending     <= pending_next;
        wr_ptr      <= wr_ptr + num;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && num != 2'd0) begin
      queue[wr_ptr] <= res0;
    end
    if (accept && num == 2'd2) begin
      queue[wr_ptr + 2'd1] <= res1;
    end
  end

endmodule

`default_nettype wire
